// ----- design/csl_pkg.sv -----
// Package for the C-subset lexer: payload types, scan modes, codes and character helpers.
`default_nettype none
package csl_pkg;

  localparam int CH_W   = 7;
  localparam int KIND_W = 4;
  localparam int VAL_W  = 32;
  localparam int KW_W   = 4;
  localparam int HASH_W = 24;
  localparam int LINE_W = 24;
  localparam int NLEN_W = 3;
  localparam int PFX_N  = 6;
  localparam int KW_N   = 10;
  localparam int Q_N    = 3;

  localparam logic [HASH_W-1:0] HASH_START = 24'd5381;
  localparam logic [HASH_W-1:0] HASH_MUL   = 24'd66;
  localparam logic [LINE_W-1:0] LINE_MAX   = 24'hFF_FFFF;
  localparam logic [NLEN_W-1:0] NLEN_MAX   = 3'd7;

  // result kinds
  localparam logic [KIND_W-1:0] K_ERR    = 4'd0;
  localparam logic [KIND_W-1:0] K_END    = 4'd1;
  localparam logic [KIND_W-1:0] K_NUM    = 4'd2;
  localparam logic [KIND_W-1:0] K_CHR    = 4'd3;
  localparam logic [KIND_W-1:0] K_STREND = 4'd4;
  localparam logic [KIND_W-1:0] K_ID     = 4'd5;
  localparam logic [KIND_W-1:0] K_KW     = 4'd6;
  localparam logic [KIND_W-1:0] K_OP     = 4'd7;
  localparam logic [KIND_W-1:0] K_STRCH  = 4'd8;

  // characters with a role of their own
  localparam logic [CH_W-1:0] CH_NUL   = 7'h00;
  localparam logic [CH_W-1:0] CH_BS    = 7'h08;
  localparam logic [CH_W-1:0] CH_LF    = 7'h0a;
  localparam logic [CH_W-1:0] CH_CR    = 7'h0d;
  localparam logic [CH_W-1:0] CH_SP    = 7'h20;
  localparam logic [CH_W-1:0] CH_BANG  = 7'h21;
  localparam logic [CH_W-1:0] CH_DQ    = 7'h22;
  localparam logic [CH_W-1:0] CH_AMP   = 7'h26;
  localparam logic [CH_W-1:0] CH_SQ    = 7'h27;
  localparam logic [CH_W-1:0] CH_STAR  = 7'h2a;
  localparam logic [CH_W-1:0] CH_PLUS  = 7'h2b;
  localparam logic [CH_W-1:0] CH_MINUS = 7'h2d;
  localparam logic [CH_W-1:0] CH_SLASH = 7'h2f;
  localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CH_W-1:0] CH_LT    = 7'h3c;
  localparam logic [CH_W-1:0] CH_EQ    = 7'h3d;
  localparam logic [CH_W-1:0] CH_GT    = 7'h3e;
  localparam logic [CH_W-1:0] CH_BSL   = 7'h5c;
  localparam logic [CH_W-1:0] CH_B     = 7'h62;
  localparam logic [CH_W-1:0] CH_N     = 7'h6e;
  localparam logic [CH_W-1:0] CH_R     = 7'h72;
  localparam logic [CH_W-1:0] CH_BAR   = 7'h7c;

  // two-character operator codes
  localparam logic [CH_W-1:0] SYM_EQEQ = 7'h65;
  localparam logic [CH_W-1:0] SYM_LE   = 7'h6c;
  localparam logic [CH_W-1:0] SYM_GE   = 7'h67;
  localparam logic [CH_W-1:0] SYM_NE   = 7'h6e;
  localparam logic [CH_W-1:0] SYM_INC  = 7'h69;
  localparam logic [CH_W-1:0] SYM_DEC  = 7'h64;
  localparam logic [CH_W-1:0] SYM_AND  = 7'h61;
  localparam logic [CH_W-1:0] SYM_OR   = 7'h6f;
  localparam logic [CH_W-1:0] SYM_NONE = 7'h00;

  typedef enum logic [11:0] {
    M_IDLE      = 12'b0000_0000_0001,
    M_NUM       = 12'b0000_0000_0010,
    M_IDENT     = 12'b0000_0000_0100,
    M_STR       = 12'b0000_0000_1000,
    M_STR_ESC   = 12'b0000_0001_0000,
    M_CHR_OPEN  = 12'b0000_0010_0000,
    M_CHR_ESC   = 12'b0000_0100_0000,
    M_CHR_CLOSE = 12'b0000_1000_0000,
    M_OP        = 12'b0001_0000_0000,
    M_LINE_CMT  = 12'b0010_0000_0000,
    M_BLK_CMT   = 12'b0100_0000_0000,
    M_BLK_STAR  = 12'b1000_0000_0000
  } mode_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    logic [KW_W-1:0]   keyword_index;
    logic [CH_W-1:0]   symbol;
    logic [HASH_W-1:0] name_hash;
    logic [LINE_W-1:0] line;
    logic              last;
  } out_beat_t;

  typedef logic [PFX_N-1:0][CH_W-1:0] prefix_t;

  typedef struct packed {
    logic            hit;
    logic [KW_W-1:0] idx;
  } kw_hit_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= 7'h30) && (c <= 7'h39);
  endfunction

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return ((c >= 7'h61) && (c <= 7'h7a)) || ((c >= 7'h41) && (c <= 7'h5a)) || (c == 7'h5f);
  endfunction

  // separators and operators that stand alone
  function automatic logic is_single_op(input logic [CH_W-1:0] c);
    logic r;
    case (c) inside
      7'h7b, 7'h7d, 7'h28, 7'h29, 7'h5b, 7'h5d,
      7'h2c, 7'h3b, 7'h2a, 7'h25, 7'h5e, 7'h7e: r = 1'b1;
      default:                                  r = 1'b0;
    endcase
    return r;
  endfunction

  // characters that may start a two-character operator or a comment
  function automatic logic is_pair_start(input logic [CH_W-1:0] c);
    logic r;
    case (c) inside
      CH_EQ, CH_LT, CH_GT, CH_BANG, CH_PLUS, CH_MINUS,
      CH_AMP, CH_BAR, CH_SLASH: r = 1'b1;
      default:                  r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [CH_W-1:0] decode_escape(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    case (c)
      CH_N:    r = CH_LF;
      CH_R:    r = CH_CR;
      CH_B:    r = CH_BS;
      CH_ZERO: r = CH_NUL;
      default: r = c;
    endcase
    return r;
  endfunction

  // SYM_NONE when c does not complete a pair
  function automatic logic [CH_W-1:0] pair_code(input logic [CH_W-1:0] first,
                                                input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    r = SYM_NONE;
    if (c == CH_EQ) begin
      case (first)
        CH_EQ:   r = SYM_EQEQ;
        CH_LT:   r = SYM_LE;
        CH_GT:   r = SYM_GE;
        CH_BANG: r = SYM_NE;
        default: r = SYM_NONE;
      endcase
    end else if (c == first) begin
      case (c)
        CH_PLUS:  r = SYM_INC;
        CH_MINUS: r = SYM_DEC;
        CH_AMP:   r = SYM_AND;
        CH_BAR:   r = SYM_OR;
        default:  r = SYM_NONE;
      endcase
    end
    return r;
  endfunction

  // keyword text, first character in the low bits
  function automatic prefix_t kw_text(input logic [KW_W-1:0] k);
    prefix_t r;
    unique case (k)
      4'd0:    r = {7'h00, 7'h00, 7'h64, 7'h69, 7'h6f, 7'h76};
      4'd1:    r = {7'h00, 7'h00, 7'h72, 7'h61, 7'h68, 7'h63};
      4'd2:    r = {7'h00, 7'h00, 7'h00, 7'h74, 7'h6e, 7'h69};
      4'd3:    r = {7'h00, 7'h00, 7'h6d, 7'h75, 7'h6e, 7'h65};
      4'd4:    r = {7'h00, 7'h00, 7'h00, 7'h00, 7'h66, 7'h69};
      4'd5:    r = {7'h00, 7'h00, 7'h65, 7'h73, 7'h6c, 7'h65};
      4'd6:    r = {7'h00, 7'h65, 7'h6c, 7'h69, 7'h68, 7'h77};
      4'd7:    r = {7'h00, 7'h00, 7'h00, 7'h72, 7'h6f, 7'h66};
      4'd8:    r = {7'h00, 7'h6b, 7'h61, 7'h65, 7'h72, 7'h62};
      4'd9:    r = {7'h6e, 7'h72, 7'h75, 7'h74, 7'h65, 7'h72};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [NLEN_W-1:0] kw_len(input logic [KW_W-1:0] k);
    logic [NLEN_W-1:0] r;
    unique case (k)
      4'd0, 4'd1, 4'd3, 4'd5: r = 3'd4;
      4'd2, 4'd7:             r = 3'd3;
      4'd4:                   r = 3'd2;
      4'd6, 4'd8:             r = 3'd5;
      4'd9:                   r = 3'd6;
      default:                r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic kw_hit_t kw_lookup(input prefix_t pfx, input logic [NLEN_W-1:0] len);
    kw_hit_t r;
    r = '0;
    for (int k = 0; k < KW_N; k++) begin
      if (!r.hit && (kw_len(KW_W'(k)) == len) && (kw_text(KW_W'(k)) == pfx)) begin
        r.hit = 1'b1;
        r.idx = KW_W'(k);
      end
    end
    return r;
  endfunction

  function automatic out_beat_t mk_res(input logic [KIND_W-1:0] kind,
                                       input logic [VAL_W-1:0]  value,
                                       input logic [KW_W-1:0]   kw,
                                       input logic [CH_W-1:0]   sym,
                                       input logic [HASH_W-1:0] hash,
                                       input logic [LINE_W-1:0] line);
    out_beat_t r;
    r.kind          = kind;
    r.value         = value;
    r.keyword_index = kw;
    r.symbol        = sym;
    r.name_hash     = hash;
    r.line          = line;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/c_subset_lexer.sv -----
// C-subset lexer: one-hot scan state machine feeding a three-entry result queue.
// A result enters the result queue when its input beat is accepted and reaches out_data from slot 0.
// Throughput: one input beat per cycle while in_stall is low; in_stall rises while two
// or more results wait in the queue, as after a beat giving two results.
// Reset (rst_n low, synchronous): scan state idle, line count one, queue empty.
// An end-of-input beat also returns the scan state and line count to reset values.
`default_nettype none
module c_subset_lexer (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire csl_pkg::in_beat_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output csl_pkg::out_beat_t  out_data
);

  csl_pkg::mode_t                       mode_r, mode_nxt;
  logic [csl_pkg::VAL_W-1:0]            num_r, num_nxt;
  logic [csl_pkg::HASH_W-1:0]           hash_r, hash_nxt;
  csl_pkg::prefix_t                     pfx_r, pfx_nxt;
  logic [csl_pkg::NLEN_W-1:0]           nlen_r, nlen_nxt;
  logic [csl_pkg::CH_W-1:0]             pend_r, pend_nxt;
  logic [csl_pkg::CH_W-1:0]             lit_r, lit_nxt;
  logic [csl_pkg::LINE_W-1:0]           line_r, line_nxt;

  csl_pkg::out_beat_t                   q_r [csl_pkg::Q_N];
  csl_pkg::out_beat_t                   q_nxt [csl_pkg::Q_N];
  logic [1:0]                           cnt_r, cnt_nxt;

  logic                                 acc, pop;
  logic                                 a_v, b_v;
  csl_pkg::out_beat_t                   a_res, b_res, res0, res1;
  logic [1:0]                           n_res;
  logic [1:0]                           base;
  logic                                 again;
  logic [csl_pkg::CH_W-1:0]             c;
  csl_pkg::kw_hit_t                     kw;
  csl_pkg::out_beat_t                   name_res;
  logic [csl_pkg::CH_W-1:0]             pc;

  assign acc       = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = cnt_r[1];
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign c         = in_data.ch;

  always_comb begin
    kw = csl_pkg::kw_lookup(pfx_r, nlen_r);
    if (kw.hit) begin
      name_res = csl_pkg::mk_res(csl_pkg::K_KW, '0, kw.idx, csl_pkg::SYM_NONE, '0, line_r);
    end else begin
      name_res = csl_pkg::mk_res(csl_pkg::K_ID, '0, '0, csl_pkg::SYM_NONE, hash_r, line_r);
    end
  end

  assign pc = csl_pkg::pair_code(pend_r, c);

  always_comb begin
    mode_nxt = mode_r;
    num_nxt  = num_r;
    hash_nxt = hash_r;
    pfx_nxt  = pfx_r;
    nlen_nxt = nlen_r;
    pend_nxt = pend_r;
    lit_nxt  = lit_r;
    line_nxt = line_r;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_res    = '0;
    b_res    = '0;
    again    = 1'b0;

    if (in_data.end_of_input) begin
      a_v = 1'b1;
      unique case (mode_r)
        csl_pkg::M_NUM:
          a_res = csl_pkg::mk_res(csl_pkg::K_NUM, num_r, '0, '0, '0, line_r);
        csl_pkg::M_IDENT:
          a_res = name_res;
        csl_pkg::M_STR, csl_pkg::M_STR_ESC:
          a_res = csl_pkg::mk_res(csl_pkg::K_STREND, '0, '0, '0, '0, line_r);
        csl_pkg::M_CHR_OPEN, csl_pkg::M_CHR_ESC:
          a_res = csl_pkg::mk_res(csl_pkg::K_ERR, '0, '0, '0, '0, line_r);
        csl_pkg::M_CHR_CLOSE:
          a_res = csl_pkg::mk_res(csl_pkg::K_CHR, csl_pkg::VAL_W'(lit_r), '0, '0, '0, line_r);
        csl_pkg::M_OP:
          a_res = csl_pkg::mk_res(csl_pkg::K_OP, '0, '0, pend_r, '0, line_r);
        default:
          a_v = 1'b0;
      endcase
      b_v      = 1'b1;
      b_res    = csl_pkg::mk_res(csl_pkg::K_END, '0, '0, '0, '0, line_r);
      mode_nxt = csl_pkg::M_IDLE;
      num_nxt  = '0;
      hash_nxt = csl_pkg::HASH_START;
      pfx_nxt  = '0;
      nlen_nxt = '0;
      pend_nxt = '0;
      lit_nxt  = '0;
      line_nxt = csl_pkg::LINE_W'(1);
    end else begin
      unique case (mode_r)
        csl_pkg::M_NUM: begin
          if (csl_pkg::is_digit(c)) begin
            num_nxt = csl_pkg::VAL_W'(num_r * 32'd10 + csl_pkg::VAL_W'(c) - 32'd48);
          end else begin
            a_v   = 1'b1;
            a_res = csl_pkg::mk_res(csl_pkg::K_NUM, num_r, '0, '0, '0, line_r);
            again = 1'b1;
          end
        end
        csl_pkg::M_IDENT: begin
          if (csl_pkg::is_letter(c) || csl_pkg::is_digit(c)) begin
            hash_nxt = csl_pkg::HASH_W'(hash_r * csl_pkg::HASH_MUL + csl_pkg::HASH_W'(c));
            for (int i = 0; i < csl_pkg::PFX_N; i++) begin
              if (nlen_r == csl_pkg::NLEN_W'(i)) pfx_nxt[i] = c;
            end
            if (nlen_r != csl_pkg::NLEN_MAX) nlen_nxt = nlen_r + 3'd1;
          end else begin
            a_v   = 1'b1;
            a_res = name_res;
            again = 1'b1;
          end
        end
        csl_pkg::M_STR: begin
          if (c == csl_pkg::CH_DQ) begin
            a_v      = 1'b1;
            a_res    = csl_pkg::mk_res(csl_pkg::K_STREND, '0, '0, '0, '0, line_r);
            mode_nxt = csl_pkg::M_IDLE;
          end else if (c == csl_pkg::CH_BSL) begin
            mode_nxt = csl_pkg::M_STR_ESC;
          end else begin
            a_v   = 1'b1;
            a_res = csl_pkg::mk_res(csl_pkg::K_STRCH, csl_pkg::VAL_W'(c), '0, '0, '0, line_r);
          end
        end
        csl_pkg::M_STR_ESC: begin
          a_v      = 1'b1;
          a_res    = csl_pkg::mk_res(csl_pkg::K_STRCH,
                                     csl_pkg::VAL_W'(csl_pkg::decode_escape(c)),
                                     '0, '0, '0, line_r);
          mode_nxt = csl_pkg::M_STR;
        end
        csl_pkg::M_CHR_OPEN: begin
          if (c == csl_pkg::CH_BSL) begin
            mode_nxt = csl_pkg::M_CHR_ESC;
          end else begin
            lit_nxt  = c;
            mode_nxt = csl_pkg::M_CHR_CLOSE;
          end
        end
        csl_pkg::M_CHR_ESC: begin
          lit_nxt  = csl_pkg::decode_escape(c);
          mode_nxt = csl_pkg::M_CHR_CLOSE;
        end
        csl_pkg::M_CHR_CLOSE: begin
          a_v = 1'b1;
          if (c == csl_pkg::CH_SQ) begin
            a_res    = csl_pkg::mk_res(csl_pkg::K_CHR, csl_pkg::VAL_W'(lit_r), '0, '0, '0,
                                       line_r);
            mode_nxt = csl_pkg::M_IDLE;
          end else begin
            a_res = csl_pkg::mk_res(csl_pkg::K_ERR, csl_pkg::VAL_W'(c), '0, '0, '0, line_r);
            again = 1'b1;
          end
        end
        csl_pkg::M_OP: begin
          if (pend_r == csl_pkg::CH_SLASH && c == csl_pkg::CH_SLASH) begin
            mode_nxt = csl_pkg::M_LINE_CMT;
          end else if (pend_r == csl_pkg::CH_SLASH && c == csl_pkg::CH_STAR) begin
            mode_nxt = csl_pkg::M_BLK_CMT;
          end else if (pc != csl_pkg::SYM_NONE) begin
            a_v      = 1'b1;
            a_res    = csl_pkg::mk_res(csl_pkg::K_OP, '0, '0, pc, '0, line_r);
            mode_nxt = csl_pkg::M_IDLE;
          end else begin
            a_v   = 1'b1;
            a_res = csl_pkg::mk_res(csl_pkg::K_OP, '0, '0, pend_r, '0, line_r);
            again = 1'b1;
          end
        end
        csl_pkg::M_LINE_CMT: begin
          if (c == csl_pkg::CH_LF) mode_nxt = csl_pkg::M_IDLE;
        end
        csl_pkg::M_BLK_CMT: begin
          if (c == csl_pkg::CH_STAR) mode_nxt = csl_pkg::M_BLK_STAR;
        end
        csl_pkg::M_BLK_STAR: begin
          if (c == csl_pkg::CH_SLASH) begin
            mode_nxt = csl_pkg::M_IDLE;
          end else if (c != csl_pkg::CH_STAR) begin
            mode_nxt = csl_pkg::M_BLK_CMT;
          end
        end
        default: again = 1'b1;
      endcase

      // start of a new token
      if (again) begin
        mode_nxt = csl_pkg::M_IDLE;
        if (c == csl_pkg::CH_SP || c == csl_pkg::CH_LF || c == csl_pkg::CH_CR) begin
          mode_nxt = csl_pkg::M_IDLE;
        end else if (csl_pkg::is_digit(c)) begin
          num_nxt  = csl_pkg::VAL_W'(c) - 32'd48;
          mode_nxt = csl_pkg::M_NUM;
        end else if (csl_pkg::is_letter(c)) begin
          hash_nxt = csl_pkg::HASH_W'(csl_pkg::HASH_START * csl_pkg::HASH_MUL
                                      + csl_pkg::HASH_W'(c));
          pfx_nxt    = '0;
          pfx_nxt[0] = c;
          nlen_nxt   = csl_pkg::NLEN_W'(1);
          mode_nxt   = csl_pkg::M_IDENT;
        end else if (c == csl_pkg::CH_DQ) begin
          mode_nxt = csl_pkg::M_STR;
        end else if (c == csl_pkg::CH_SQ) begin
          mode_nxt = csl_pkg::M_CHR_OPEN;
        end else if (csl_pkg::is_single_op(c)) begin
          b_v   = 1'b1;
          b_res = csl_pkg::mk_res(csl_pkg::K_OP, '0, '0, c, '0, line_r);
        end else if (csl_pkg::is_pair_start(c)) begin
          pend_nxt = c;
          mode_nxt = csl_pkg::M_OP;
        end else begin
          b_v   = 1'b1;
          b_res = csl_pkg::mk_res(csl_pkg::K_ERR, csl_pkg::VAL_W'(c), '0, '0, '0, line_r);
        end
      end

      if (c == csl_pkg::CH_LF && line_r != csl_pkg::LINE_MAX) line_nxt = line_r + 24'd1;
    end
  end

  // pack results, mark the final one
  always_comb begin
    res0  = a_v ? a_res : b_res;
    res1  = b_res;
    n_res = {1'b0, a_v} + {1'b0, b_v};
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  // result queue: slot 0 is the head
  always_comb begin
    base = cnt_r - {1'b0, pop};
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = pop ? q_r[2] : q_r[1];
    q_nxt[2] = q_r[2];
    for (int i = 0; i < csl_pkg::Q_N; i++) begin
      if (acc && n_res != 2'd0 && base == 2'(i)) q_nxt[i] = res0;
      if (acc && n_res == 2'd2 && base + 2'd1 == 2'(i)) q_nxt[i] = res1;
    end
    cnt_nxt = acc ? base + n_res : base;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < csl_pkg::Q_N; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      mode_r <= csl_pkg::M_IDLE;
      num_r  <= '0;
      hash_r <= csl_pkg::HASH_START;
      pfx_r  <= '0;
      nlen_r <= '0;
      pend_r <= '0;
      lit_r  <= '0;
      line_r <= csl_pkg::LINE_W'(1);
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        mode_r <= mode_nxt;
        num_r  <= num_nxt;
        hash_r <= hash_nxt;
        pfx_r  <= pfx_nxt;
        nlen_r <= nlen_nxt;
        pend_r <= pend_nxt;
        lit_r  <= lit_nxt;
        line_r <= line_nxt;
      end
    end
  end

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.end_of_input |=> mode_r == csl_pkg::M_IDLE && line_r == 24'd1)
    else $error("scan state not cleared after end of input");

  a_eoi_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.end_of_input |=> out_valid)
    else $error("no end token queued after end of input");

  a_str_char_one: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_data.end_of_input && mode_r == csl_pkg::M_STR &&
    in_data.ch != csl_pkg::CH_DQ && in_data.ch != csl_pkg::CH_BSL
    |=> cnt_r == $past(cnt_r) + 2'd1 - {1'b0, $past(pop)})
    else $error("string character beat did not queue exactly one result");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> line_r != 24'd0)
    else $error("line count reached zero");

endmodule
`default_nettype wire
